FILE: rtl/core/i2a_pkg.sv
package i2a_pkg;

  // conversion kinds
  localparam logic [2:0] KIND_SDEC  = 3'd0;
  localparam logic [2:0] KIND_UDEC  = 3'd1;
  localparam logic [2:0] KIND_HEXL  = 3'd2;
  localparam logic [2:0] KIND_HEXU  = 3'd3;
  localparam logic [2:0] KIND_PTR   = 3'd4;

  // digit register geometry: twenty nibbles cover 64-bit decimal and hex
  localparam int MaxDigits = 20;
  localparam int DigitW    = 4;
  localparam int BcdW      = MaxDigits * DigitW;

  // ascii codes and offsets
  localparam logic [7:0] AsciiZero   = 8'd48;
  localparam logic [7:0] AsciiMinus  = 8'd45;
  localparam logic [7:0] AsciiX      = 8'd120;
  localparam logic [7:0] LowerOffset = 8'd39;
  localparam logic [7:0] UpperOffset = 8'd7;

  typedef struct packed {
    logic [63:0] value;
    logic [2:0]  kind;
  } in_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
    logic [4:0] length;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // operations of the shared digit unit
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD_DEC,
    OP_LOAD_HEX,
    OP_DABBLE,
    OP_SHIFT_DIGIT
  } op_t;

endpackage

FILE: rtl/core/integer_to_ascii_formatter_core.sv
// Integer to ASCII formatter.
// Input channel (in_valid / in_stall / in_data) takes a value and a kind:
// signed decimal of the low 32 bits, unsigned decimal, lower or upper hex,
// or pointer hex with a 0x prefix. Kinds 5 to 7 are taken and dropped.
// Output channel (out_valid / out_stall / out_data) gives one ASCII
// character per transfer, most significant digit first, with the total
// length on every transfer and last on the final one.
// One item at a time: in_stall is high from the cycle after an item is
// taken until its last character sits in the output register.
// An item passes a load step, VALUE_WIDTH double-dabble steps in the
// shared digit unit (decimal kinds only), and a zero scan that drops up to
// 19 leading zero digits and then fixes the length; it then gives one
// character per cycle while the receiver does not stall.
// A stalled receiver holds the current character and holds the sequencer in
// its emit phase for as long as the stall lasts.
// Reset clears the sequencer and output valid; nothing else needs it.
module integer_to_ascii_formatter_core
  import i2a_pkg::*;
#(
  parameter int VALUE_WIDTH = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int CntW = $clog2(VALUE_WIDTH + 1);

  state_t                 state, state_next;
  logic [CntW-1:0]        cnt, cnt_next;
  logic [4:0]             nd, nd_next;
  logic [1:0]             pre_left, pre_left_next;
  logic                   ptr_kind, ptr_kind_next;
  logic                   upper, upper_next;
  logic [4:0]             len, len_next;
  logic                   out_valid_next;
  out_t                   out_data_next;
  op_t                    op;
  logic [VALUE_WIDTH-1:0] load_bin;
  logic [DigitW-1:0]      top_digit;
  logic [31:0]            low;
  logic [31:0]            mag;
  logic [7:0]             digit_char;

  i2a_digit_unit #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_digit (
    .clk      (clk),
    .op       (op),
    .load_bin (load_bin),
    .top_digit(top_digit)
  );

  // operand for the digit unit: magnitude for signed decimal, else raw value
  assign low = in_data.value[31:0];
  assign mag = low[31] ? (~low + 32'd1) : low;
  assign load_bin = (in_data.kind == KIND_SDEC) ? VALUE_WIDTH'(mag)
                                                : in_data.value[VALUE_WIDTH-1:0];

  // ascii of the current top digit
  always_comb begin
    digit_char = AsciiZero + {4'd0, top_digit};
    if (top_digit >= 4'd10) begin
      digit_char = digit_char + (upper ? UpperOffset : LowerOffset);
    end
  end

  assign in_stall = (state != ST_IDLE);

  // sequencer
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    nd_next        = nd;
    pre_left_next  = pre_left;
    ptr_kind_next  = ptr_kind;
    upper_next     = upper;
    len_next       = len;
    out_valid_next = out_valid && out_stall;
    out_data_next  = out_data;
    op             = OP_HOLD;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_data.kind <= KIND_PTR) begin
          upper_next    = (in_data.kind == KIND_HEXU);
          ptr_kind_next = (in_data.kind == KIND_PTR);
          nd_next       = 5'(MaxDigits);
          if (in_data.kind == KIND_PTR) begin
            pre_left_next = 2'd2;
          end else if (in_data.kind == KIND_SDEC && low[31]) begin
            pre_left_next = 2'd1;
          end else begin
            pre_left_next = 2'd0;
          end
          if (in_data.kind inside {KIND_SDEC, KIND_UDEC}) begin
            op         = OP_LOAD_DEC;
            cnt_next   = CntW'(VALUE_WIDTH);
            state_next = ST_CONV;
          end else begin
            op         = OP_LOAD_HEX;
            state_next = ST_SCAN;
          end
        end
      end
      ST_CONV: begin
        op       = OP_DABBLE;
        cnt_next = cnt - CntW'(1);
        if (cnt == CntW'(1)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // drop leading zero digits, keeping at least one
        if (top_digit == 4'd0 && nd > 5'd1) begin
          op      = OP_SHIFT_DIGIT;
          nd_next = nd - 5'd1;
        end else begin
          len_next   = nd + {3'd0, pre_left};
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          out_valid_next       = 1'b1;
          out_data_next.length = len;
          out_data_next.last   = (pre_left == 2'd0) && (nd == 5'd1);
          if (pre_left == 2'd2) begin
            out_data_next.character = AsciiZero;
            pre_left_next           = 2'd1;
          end else if (pre_left == 2'd1) begin
            out_data_next.character = ptr_kind ? AsciiX : AsciiMinus;
            pre_left_next           = 2'd0;
          end else begin
            out_data_next.character = digit_char;
            op                      = OP_SHIFT_DIGIT;
            nd_next                 = nd - 5'd1;
            if (nd == 5'd1) begin
              state_next = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    cnt      <= cnt_next;
    nd       <= nd_next;
    pre_left <= pre_left_next;
    ptr_kind <= ptr_kind_next;
    upper    <= upper_next;
    len      <= len_next;
    out_data <= out_data_next;
  end

  // a shown character always carries a legal total length
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.length != 5'd0 && out_data.length <= 5'd20))
    else $error("output length out of range");

  // a character that is not the last one means the sequencer is still emitting
  a_not_last_emit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.last) |-> (state == ST_EMIT))
    else $error("non-last character with sequencer not emitting");

  // a legal item starts conversion or the zero scan
  a_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_data.kind <= KIND_PTR)
      |=> (state == ST_CONV || state == ST_SCAN))
    else $error("accepted item did not start");

  // while emitting there is always at least one digit left
  a_digits_left: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (nd != 5'd0))
    else $error("digit count ran out while emitting");

endmodule

FILE: rtl/core/i2a_digit_unit.sv
module i2a_digit_unit
  import i2a_pkg::*;
#(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                   clk,
  input  op_t                    op,
  input  logic [VALUE_WIDTH-1:0] load_bin,
  output logic [DigitW-1:0]      top_digit
);

  logic [BcdW-1:0]        bcd;
  logic [VALUE_WIDTH-1:0] bin;
  logic [BcdW-1:0]        adj;

  // add-3 correction on every bcd digit ahead of the shift
  always_comb begin
    for (int i = 0; i < MaxDigits; i++) begin
      if (bcd[i*DigitW +: DigitW] >= 4'd5) begin
        adj[i*DigitW +: DigitW] = bcd[i*DigitW +: DigitW] + 4'd3;
      end else begin
        adj[i*DigitW +: DigitW] = bcd[i*DigitW +: DigitW];
      end
    end
  end

  // shared shift register: load, double dabble step or one-digit shift out
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD_DEC: begin
        bcd <= '0;
        bin <= load_bin;
      end
      OP_LOAD_HEX: begin
        bcd <= BcdW'(load_bin);
        bin <= load_bin;
      end
      OP_DABBLE: begin
        bcd <= {adj[BcdW-2:0], bin[VALUE_WIDTH-1]};
        bin <= {bin[VALUE_WIDTH-2:0], 1'b0};
      end
      OP_SHIFT_DIGIT: begin
        bcd <= {bcd[BcdW-DigitW-1:0], {DigitW{1'b0}}};
      end
      default: begin
      end
    endcase
  end

  assign top_digit = bcd[BcdW-1 -: DigitW];

endmodule
